// ----- src/psm_pkg.sv -----
// Package: shared types and constants of the p-code stack machine step block.
`timescale 1ns / 1ps
package psm_pkg;

  localparam int unsigned STACK_DEPTH   = 512;
  localparam int unsigned PROGRAM_DEPTH = 1024;
  localparam int unsigned STACK_AW      = $clog2(STACK_DEPTH);
  localparam int unsigned PC_W          = $clog2(PROGRAM_DEPTH);
  localparam int unsigned DATA_W        = 64;
  localparam int unsigned SHADOW_N      = 3;

  localparam logic [DATA_W-1:0] RESET_E0 = 64'd35;
  localparam logic [DATA_W-1:0] RESET_E1 = 64'd36;
  localparam logic [DATA_W-1:0] RESET_E2 = 64'd37;
  localparam logic [DATA_W-1:0] CAL_E0   = 64'd100;
  localparam logic [DATA_W-1:0] CAL_E1   = 64'd500;
  localparam logic [DATA_W-1:0] CAL_E2   = 64'd256;
  localparam logic [PC_W-1:0]   RESET_PC = PC_W'(1);
  localparam logic [9:0]        RESET_HALT = 10'd35;

  typedef enum logic [3:0] {
    OP_END = 4'd0, OP_LIT = 4'd1, OP_OPR = 4'd2, OP_LOD = 4'd3,
    OP_STO = 4'd4, OP_CAL = 4'd5, OP_INC = 4'd6, OP_JMP = 4'd7,
    OP_JPC = 4'd8, OP_WRT = 4'd9, OP_INT = 4'd10
  } op_e;

  localparam logic [31:0] OPR_NEG = 32'd1;
  localparam logic [31:0] OPR_ADD = 32'd2;
  localparam logic [31:0] OPR_SUB = 32'd3;
  localparam logic [31:0] OPR_MUL = 32'd4;
  localparam logic [31:0] OPR_DIV = 32'd5;
  localparam logic [31:0] OPR_ODD = 32'd6;
  localparam logic [31:0] OPR_MOD = 32'd7;
  localparam logic [31:0] OPR_EQL = 32'd8;
  localparam logic [31:0] OPR_NEQ = 32'd9;
  localparam logic [31:0] OPR_LSS = 32'd10;
  localparam logic [31:0] OPR_LEQ = 32'd11;
  localparam logic [31:0] OPR_GTR = 32'd12;
  localparam logic [31:0] OPR_GEQ = 32'd13;

  typedef enum logic [1:0] {
    FLT_NONE = 2'd0, FLT_STACK = 2'd1, FLT_OP = 2'd2, FLT_PC = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    MD_MUL = 2'd0, MD_DIV = 2'd1, MD_MOD = 2'd2
  } md_mode_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_T, S_RD_B, S_EXEC, S_MD, S_WR, S_RD_O, S_DONE
  } state_e;

  typedef struct packed {
    logic        start;
    md_mode_e    mode;
  } md_req_t;

  typedef struct packed {
    logic        done;
  } md_rsp_t;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] operand;
  } in_t;

  typedef struct packed {
    logic [9:0]         next_pc;
    logic [8:0]         top_index;
    logic signed [63:0] top_value;
    logic               write_valid;
    logic signed [63:0] write_value;
    logic               halted;
    logic [1:0]         fault;
    logic [31:0]        executed_count;
  } out_t;

endpackage

// ----- src/psm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module psm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/psm_muldiv.sv -----
// Bit-serial 64-bit multiplier and signed restoring divider.
`timescale 1ns / 1ps
module psm_muldiv (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  psm_pkg::md_req_t             req_i,
  input  logic [psm_pkg::DATA_W-1:0]   a_i,
  input  logic [psm_pkg::DATA_W-1:0]   b_i,
  output psm_pkg::md_rsp_t             rsp_o,
  output logic [psm_pkg::DATA_W-1:0]   result_o
);
  import psm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DATA_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  md_mode_e          mode_q, mode_d;
  logic              neg_q, neg_d;
  logic [DATA_W-1:0] acc_q, acc_d, x_q, x_d, y_q, y_d;
  logic [DATA_W-1:0] rem_sh, mag_a, mag_b;

  assign mag_a  = a_i[DATA_W-1] ? (DATA_W'(0) - a_i) : a_i;
  assign mag_b  = b_i[DATA_W-1] ? (DATA_W'(0) - b_i) : b_i;
  assign rem_sh = {acc_q[DATA_W-2:0], x_q[DATA_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mode_d = mode_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mode_d = req_i.mode;
      acc_d  = '0;
      if (req_i.mode == MD_MUL) begin
        x_d = a_i;
        y_d = b_i;
      end else begin
        x_d = mag_a;
        y_d = mag_b;
      end
      neg_d = (req_i.mode == MD_DIV) ? (a_i[DATA_W-1] ^ b_i[DATA_W-1]) : a_i[DATA_W-1];
    end else if (busy_q) begin
      if (mode_q == MD_MUL) begin
        if (y_q[0]) begin
          acc_d = acc_q + x_q;
        end
        x_d = {x_q[DATA_W-2:0], 1'b0};
        y_d = {1'b0, y_q[DATA_W-1:1]};
      end else begin
        if (rem_sh >= y_q) begin
          acc_d = rem_sh - y_q;
          x_d   = {x_q[DATA_W-2:0], 1'b1};
        end else begin
          acc_d = rem_sh;
          x_d   = {x_q[DATA_W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(DATA_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
    x_q    <= x_d;
    y_q    <= y_d;
  end

  always_comb begin
    case (mode_q)
      MD_DIV:  result_o = neg_q ? (DATA_W'(0) - x_q) : x_q;
      MD_MOD:  result_o = neg_q ? (DATA_W'(0) - acc_q) : acc_q;
      default: result_o = acc_q;
    endcase
  end

  assign rsp_o.done = done_q;

endmodule

// ----- src/pcode_stack_machine_step.sv -----
// Top level: p-code stack machine executing one instruction per input beat.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one instruction
//   per beat: opcode and 32-bit signed operand. Output channel (out_valid_o /
//   out_stall_i / out_data_o) returns one result beat per instruction: next pc,
//   top index and value, WRT output, halted flag, fault code, executed count.
//   cfg_we_i / cfg_data_i write halt_address; write only while idle.
// Timing
//   One instruction at a time. Read top, read second operand, execute, write
//   back, read new top, then register the result beat. MUL, and DIV or MOD
//   with a nonzero divisor, go through the bit-serial unit between execute and
//   write back. The next instruction is accepted the cycle after the result is
//   registered.
//   The stack lives in a 512 x 64 RAM with one read and one write port;
//   entries 0..2 also live in flops so they have reset values.
// Reset
//   Entries 0..2 = 35,36,37, top 0, pc 1, count 0, halt_address 35.
//   No clearing pass; other stack entries are undefined until written.
// Stall
//   A stalled result holds in the output register; the machine waits with
//   the next result until the register frees, and stalls its input meanwhile.
module pcode_stack_machine_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  psm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output psm_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [9:0]    cfg_data_i
);
  import psm_pkg::*;

  state_e state_q, state_d;

  logic [3:0]          op_q;
  logic [31:0]         arg_q;
  logic [STACK_AW-1:0] t_q, t_d;
  logic [PC_W-1:0]     pc_q, pc_d;
  logic [31:0]         cnt_q;
  logic [9:0]          halt_q;
  logic [DATA_W-1:0]   sh_q [SHADOW_N];
  logic [DATA_W-1:0]   b_q;
  logic [STACK_AW-1:0] raddr_q, raddr;
  logic                re;

  // staged commit
  logic                we_q, we_x;
  logic [STACK_AW-1:0] waddr_q, waddr_x;
  logic [DATA_W-1:0]   wdata_q, wdata_x;
  logic                cal_q, cal_x;
  logic [STACK_AW-1:0] tn_q, t_x;
  logic [PC_W-1:0]     pcn_q, pc_x;
  fault_e              fault_q, fault_x;
  logic                wv_q, wv_x;
  logic                md_need;
  md_mode_e            md_mode;

  logic                out_valid_q;
  out_t                out_q;

  logic [DATA_W-1:0]   ram_rdata, rdata_eff, a, arg_sx;
  logic                arg_stk_ok, arg_pc_ok, sh0_pc_ok;
  logic [PC_W-1:0]     seq;

  md_req_t             md_req;
  md_rsp_t             md_rsp;
  logic [DATA_W-1:0]   md_result;

  logic                out_free;

  psm_ram #(.WIDTH(DATA_W), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (state_q == S_WR && we_q),
    .waddr_i (waddr_q),
    .wdata_i (wdata_q),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  psm_muldiv u_md (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (md_req),
    .a_i      (a),
    .b_i      (b_q),
    .rsp_o    (md_rsp),
    .result_o (md_result)
  );

  // low entries come from the flop copies
  assign rdata_eff = (raddr_q < STACK_AW'(SHADOW_N)) ? sh_q[raddr_q[1:0]] : ram_rdata;
  assign a         = rdata_eff;
  assign arg_sx    = {{(DATA_W-32){arg_q[31]}}, arg_q};
  assign arg_stk_ok = !arg_q[31] && (arg_q[30:0] < 31'(STACK_DEPTH));
  assign arg_pc_ok  = !arg_q[31] && (arg_q[30:0] < 31'(PROGRAM_DEPTH));
  assign sh0_pc_ok  = !sh_q[0][DATA_W-1] && (sh_q[0][DATA_W-2:0] < 63'(PROGRAM_DEPTH));
  assign seq        = pc_q + PC_W'(1);
  assign out_free   = !out_valid_q || !out_stall_i;

  // read port addressing
  always_comb begin
    re    = 1'b0;
    raddr = t_q;
    unique case (state_q)
      S_RD_T: begin
        re = 1'b1;
      end
      S_RD_B: begin
        re    = 1'b1;
        raddr = (op_q == OP_LOD) ? arg_q[STACK_AW-1:0] : (t_q - STACK_AW'(1));
      end
      S_RD_O: begin
        re = 1'b1;
      end
      default: begin
        re = 1'b0;
      end
    endcase
  end

  // instruction decode and execute, valid in S_EXEC
  always_comb begin
    pc_x    = seq;
    t_x     = t_q;
    we_x    = 1'b0;
    waddr_x = t_q;
    wdata_x = arg_sx;
    cal_x   = 1'b0;
    fault_x = FLT_NONE;
    wv_x    = 1'b0;
    md_need = 1'b0;
    md_mode = MD_MUL;
    case (op_q)
      OP_END: begin
        if (sh0_pc_ok) pc_x = sh_q[0][PC_W-1:0];
        else fault_x = FLT_PC;
      end
      OP_LIT: begin
        we_x = 1'b1;
      end
      OP_OPR: begin
        if (arg_q == OPR_NEG) begin
          we_x    = 1'b1;
          wdata_x = DATA_W'(0) - b_q;
        end else if (arg_q == OPR_ODD) begin
          we_x    = 1'b1;
          wdata_x = {{(DATA_W-1){1'b0}}, b_q[0]};
        end else if (arg_q >= OPR_ADD && arg_q <= OPR_GEQ) begin
          if (t_q == '0) begin
            fault_x = FLT_STACK;
          end else begin
            we_x    = 1'b1;
            waddr_x = t_q - STACK_AW'(1);
            t_x     = t_q - STACK_AW'(1);
            case (arg_q)
              OPR_ADD: wdata_x = a + b_q;
              OPR_SUB: wdata_x = a - b_q;
              OPR_MUL: begin
                md_need = 1'b1;
                md_mode = MD_MUL;
              end
              OPR_DIV: begin
                wdata_x = a;
                md_need = (b_q != '0);
                md_mode = MD_DIV;
              end
              OPR_MOD: begin
                wdata_x = a;
                md_need = (b_q != '0);
                md_mode = MD_MOD;
              end
              OPR_EQL: wdata_x = DATA_W'(a == b_q);
              OPR_NEQ: wdata_x = DATA_W'(a != b_q);
              OPR_LSS: wdata_x = DATA_W'($signed(a) < $signed(b_q));
              OPR_LEQ: wdata_x = DATA_W'($signed(a) <= $signed(b_q));
              OPR_GTR: wdata_x = DATA_W'($signed(a) > $signed(b_q));
              default: wdata_x = DATA_W'($signed(a) >= $signed(b_q));
            endcase
          end
        end else begin
          fault_x = FLT_OP;
        end
      end
      OP_LOD: begin
        if (arg_stk_ok) begin
          we_x    = 1'b1;
          wdata_x = a;
        end else fault_x = FLT_STACK;
      end
      OP_STO: begin
        if (arg_stk_ok) begin
          we_x    = 1'b1;
          waddr_x = arg_q[STACK_AW-1:0];
          wdata_x = b_q;
        end else fault_x = FLT_STACK;
      end
      OP_CAL: begin
        if (arg_pc_ok) begin
          cal_x = 1'b1;
          pc_x  = arg_q[PC_W-1:0];
        end else fault_x = FLT_PC;
      end
      OP_INC: begin
        if (t_q != STACK_AW'(STACK_DEPTH - 1)) t_x = t_q + STACK_AW'(1);
        else fault_x = FLT_STACK;
      end
      OP_JMP: begin
        if (arg_pc_ok) pc_x = arg_q[PC_W-1:0];
        else fault_x = FLT_PC;
      end
      OP_JPC: begin
        if (b_q == '0) begin
          if (!arg_pc_ok) fault_x = FLT_PC;
          else if (t_q == '0) fault_x = FLT_STACK;
          else begin
            pc_x = arg_q[PC_W-1:0];
            t_x  = t_q - STACK_AW'(1);
          end
        end
      end
      OP_WRT: begin
        if (t_q == '0) fault_x = FLT_STACK;
        else begin
          wv_x = 1'b1;
          t_x  = t_q - STACK_AW'(1);
        end
      end
      OP_INT: begin
        if (arg_stk_ok) t_x = arg_q[STACK_AW-1:0];
        else fault_x = FLT_STACK;
      end
      default: begin
        fault_x = FLT_OP;
      end
    endcase
  end

  assign md_req.start = (state_q == S_EXEC) && md_need;
  assign md_req.mode  = md_mode;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RD_T;
      S_RD_T: state_d = S_RD_B;
      S_RD_B: state_d = S_EXEC;
      S_EXEC: state_d = md_need ? S_MD : S_WR;
      S_MD:   if (md_rsp.done) state_d = S_WR;
      S_WR:   state_d = S_RD_O;
      S_RD_O: state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    t_d        = t_q;
    pc_d       = pc_q;
    if (state_q == S_WR) begin
      t_d  = tn_q;
      pc_d = pcn_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      t_q         <= '0;
      pc_q        <= RESET_PC;
      cnt_q       <= '0;
      halt_q      <= RESET_HALT;
      sh_q[0]     <= RESET_E0;
      sh_q[1]     <= RESET_E1;
      sh_q[2]     <= RESET_E2;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      t_q     <= t_d;
      pc_q    <= pc_d;
      if (cfg_we_i) halt_q <= cfg_data_i;
      if (state_q == S_WR) begin
        if (cnt_q != '1) cnt_q <= cnt_q + 32'd1;
        if (cal_q) begin
          sh_q[0] <= CAL_E0;
          sh_q[1] <= CAL_E1;
          sh_q[2] <= CAL_E2;
        end else if (we_q && waddr_q < STACK_AW'(SHADOW_N)) begin
          sh_q[waddr_q[1:0]] <= wdata_q;
        end
      end
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      op_q  <= in_data_i.opcode;
      arg_q <= in_data_i.operand;
    end
    if (re) raddr_q <= raddr;
    if (state_q == S_RD_B) b_q <= rdata_eff;
    if (state_q == S_EXEC) begin
      we_q    <= we_x && (fault_x == FLT_NONE);
      waddr_q <= waddr_x;
      wdata_q <= wdata_x;
      cal_q   <= cal_x;
      tn_q    <= t_x;
      pcn_q   <= pc_x;
      fault_q <= fault_x;
      wv_q    <= wv_x;
    end
    if (state_q == S_MD && md_rsp.done) wdata_q <= md_result;
    if (state_q == S_DONE && out_free) begin
      out_q.next_pc        <= 10'(pc_q);
      out_q.top_index      <= 9'(t_q);
      out_q.top_value      <= rdata_eff;
      out_q.write_valid    <= wv_q;
      out_q.write_value    <= wv_q ? b_q : '0;
      out_q.halted         <= (10'(pc_q) == halt_q);
      out_q.fault          <= fault_q;
      out_q.executed_count <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
